FILE: rtl/svps_pkg.sv
// Shared types, constants and the coil table of the stepper valve sequencer.
package svps_pkg;

    localparam int POS_W   = 13;
    localparam int STEPS_W = 14;
    localparam int HOLD_W  = 12;
    localparam int WAIT_W  = 8;
    localparam int OFF_W   = 16;
    localparam int MODE_W  = 3;
    localparam int COIL_W  = 4;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;

    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [STEPS_W-1:0] steps_t;
    typedef logic [HOLD_W-1:0]         hold_t;
    typedef logic [WAIT_W-1:0]         wait_t;
    typedef logic [OFF_W-1:0]          off_t;
    typedef logic [MODE_W-1:0]         mode_t;
    typedef logic [COIL_W-1:0]         coil_t;
    typedef logic [2:0]                phase_t;

    // Item modes
    localparam mode_t MODE_STEP    = 3'd0;
    localparam mode_t MODE_CONTROL = 3'd1;
    localparam mode_t MODE_COLD    = 3'd2;
    localparam mode_t MODE_ICE     = 3'd3;
    localparam mode_t MODE_HOME    = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_HOME_POS   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_COLD_POS   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_ICE_POS    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_HOLD_TICKS = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_POWER_ON   = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_OFF_LIMIT  = 3'd5;

    // Reset values of the registers
    localparam pos_t  HOME_POS_RST   = -13'sd1000;
    localparam pos_t  COLD_POS_RST   = 13'sd100;
    localparam pos_t  ICE_POS_RST    = 13'sd300;
    localparam hold_t HOLD_TICKS_RST = 12'd50;
    localparam wait_t POWER_ON_RST   = 8'd10;
    localparam off_t  OFF_LIMIT_RST  = 16'd2400;

    localparam pos_t POS_MAX = 13'sd4095;
    localparam pos_t POS_MIN = -13'sd4096;

    // Request bits
    localparam int REQ_HOME = 0;
    localparam int REQ_COLD = 1;
    localparam int REQ_ICE  = 2;

    // Command from the sequencer to the motor drive
    typedef struct packed {
        logic arm;
        logic zero;
        pos_t where;
    } motor_cmd_t;

    // Half-step wheel: bit3 coil one .. bit0 coil four
    function automatic coil_t coil_of_phase(input phase_t ph);
        coil_t c;
        case (ph)
            3'd0:    c = 4'h9;
            3'd1:    c = 4'h1;
            3'd2:    c = 4'h3;
            3'd3:    c = 4'h2;
            3'd4:    c = 4'h6;
            3'd5:    c = 4'h4;
            3'd6:    c = 4'hC;
            3'd7:    c = 4'h8;
            default: c = 4'h0;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/svps_motor.sv
// Half-step motor drive: position, hold counters, phase wheel and coil pattern.
module svps_motor (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic                step_en,
    input  svps_pkg::motor_cmd_t cmd,
    input  svps_pkg::hold_t     hold_ticks,
    output svps_pkg::pos_t      cur_pos,
    output svps_pkg::pos_t      tgt_pos,
    output svps_pkg::coil_t     coil_next,
    output svps_pkg::pos_t      pos_next
);

    svps_pkg::pos_t   cur_reg, cur_next;
    svps_pkg::pos_t   tgt_reg, tgt_next;
    svps_pkg::steps_t steps_reg, steps_next;
    svps_pkg::hold_t  start_reg, start_next;
    svps_pkg::hold_t  stop_reg, stop_next;
    svps_pkg::phase_t ph_now_reg, ph_now_next;
    svps_pkg::phase_t ph_bef_reg, ph_bef_next;
    svps_pkg::coil_t  coil_reg, coil_next_int;

    svps_pkg::steps_t diff;
    logic             load;
    svps_pkg::steps_t steps_eff;
    svps_pkg::hold_t  start_eff;
    svps_pkg::hold_t  stop_eff;

    assign diff = svps_pkg::steps_t'(tgt_reg) - svps_pkg::steps_t'(cur_reg);
    assign load = (steps_reg == '0) && (tgt_reg != cur_reg);
    assign steps_eff = load ? diff : steps_reg;
    assign start_eff = load ? hold_ticks : start_reg;
    assign stop_eff  = load ? hold_ticks : stop_reg;

    // Work out one step tick or apply a sequencer command
    always_comb begin
        cur_next      = cur_reg;
        tgt_next      = tgt_reg;
        steps_next    = steps_reg;
        start_next    = start_reg;
        stop_next     = stop_reg;
        ph_now_next   = ph_now_reg;
        ph_bef_next   = ph_bef_reg;
        coil_next_int = coil_reg;
        if (step_en) begin
            steps_next = steps_eff;
            start_next = start_eff;
            stop_next  = stop_eff;
            if (start_eff != '0) begin
                start_next    = start_eff - 1'b1;
                coil_next_int = svps_pkg::coil_of_phase(ph_bef_reg);
            end else if (steps_eff == '0) begin
                if (stop_eff != '0) begin
                    stop_next     = stop_eff - 1'b1;
                    coil_next_int = svps_pkg::coil_of_phase(ph_now_reg);
                end else begin
                    coil_next_int = '0;
                end
            end else if (!steps_eff[svps_pkg::STEPS_W-1]) begin
                steps_next    = steps_eff - 1'b1;
                cur_next      = (cur_reg != svps_pkg::POS_MAX) ? cur_reg + 1'b1 : cur_reg;
                ph_bef_next   = ph_now_reg;
                ph_now_next   = ph_now_reg + 1'b1;
                coil_next_int = svps_pkg::coil_of_phase(ph_now_reg + 1'b1);
            end else begin
                steps_next    = steps_eff + 1'b1;
                cur_next      = (cur_reg != svps_pkg::POS_MIN) ? cur_reg - 1'b1 : cur_reg;
                ph_bef_next   = ph_now_reg;
                ph_now_next   = ph_now_reg - 1'b1;
                coil_next_int = svps_pkg::coil_of_phase(ph_now_reg - 1'b1);
            end
        end else begin
            if (cmd.arm) begin
                start_next = hold_ticks;
                stop_next  = hold_ticks;
                tgt_next   = cmd.where;
            end
            if (cmd.zero) begin
                tgt_next = '0;
                cur_next = '0;
            end
        end
    end

    // Hold motor state, advance on each processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg    <= svps_pkg::ICE_POS_RST;
            tgt_reg    <= svps_pkg::ICE_POS_RST;
            steps_reg  <= '0;
            start_reg  <= '0;
            stop_reg   <= '0;
            ph_now_reg <= '0;
            ph_bef_reg <= '0;
            coil_reg   <= '0;
        end else if (advance) begin
            cur_reg    <= cur_next;
            tgt_reg    <= tgt_next;
            steps_reg  <= steps_next;
            start_reg  <= start_next;
            stop_reg   <= stop_next;
            ph_now_reg <= ph_now_next;
            ph_bef_reg <= ph_bef_next;
            coil_reg   <= coil_next_int;
        end
    end

    assign cur_pos   = cur_reg;
    assign tgt_pos   = tgt_reg;
    assign coil_next = coil_next_int;
    assign pos_next  = cur_next;

endmodule

FILE: rtl/svps_seq.sv
// Request sequencer: compressor watch, homing, cold and ice sequences.
module svps_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  svps_pkg::mode_t      mode,
    input  logic                 compressor_on,
    input  logic                 restart_delay_active,
    input  svps_pkg::off_t       off_delay_count,
    input  logic                 factory_test,
    input  svps_pkg::pos_t       home_position,
    input  svps_pkg::pos_t       cold_position,
    input  svps_pkg::pos_t       ice_position,
    input  svps_pkg::wait_t      power_on_ticks,
    input  svps_pkg::off_t       off_delay_limit,
    input  svps_pkg::pos_t       cur_pos,
    input  svps_pkg::pos_t       tgt_pos,
    output svps_pkg::motor_cmd_t cmd,
    output logic                 supply_next,
    output logic                 status_next,
    output logic                 busy_next
);

    typedef enum logic [2:0] {
        HOME_START, HOME_POWER, HOME_ARM, HOME_MOVE, HOME_ARM_COLD, HOME_MOVE_COLD,
        HOME_DONE
    } home_step_t;

    typedef enum logic [2:0] {
        GO_START, GO_POWER, GO_CHECK, GO_ARM, GO_MOVE, GO_DONE
    } go_step_t;

    logic [2:0]      req_reg, req_n;
    home_step_t      home_reg, home_n;
    go_step_t        cold_reg, cold_n;
    go_step_t        ice_reg, ice_n;
    svps_pkg::wait_t wait_reg, wait_n;
    logic            status_reg, status_n;
    logic            comp_last_reg, comp_last_n;
    logic            hp_reg, hp_n;
    logic            supply_reg, supply_n;

    go_step_t        go_step, go_next;
    svps_pkg::pos_t  go_where;
    logic            go_done;

    // Work out the next sequencer state for the current item
    always_comb begin
        req_n       = req_reg;
        home_n      = home_reg;
        cold_n      = cold_reg;
        ice_n       = ice_reg;
        wait_n      = wait_reg;
        status_n    = status_reg;
        comp_last_n = comp_last_reg;
        hp_n        = hp_reg;
        supply_n    = supply_reg;
        cmd         = '0;
        go_step     = req_reg[svps_pkg::REQ_COLD] ? cold_reg : ice_reg;
        go_where    = req_reg[svps_pkg::REQ_COLD] ? cold_position : ice_position;
        go_next     = go_step;
        go_done     = 1'b0;
        case (mode)
            svps_pkg::MODE_CONTROL: begin
                // watch the compressor and raise homing after a turn-off
                if (!factory_test) begin
                    if (comp_last_reg != compressor_on) begin
                        comp_last_n = compressor_on;
                        if (!compressor_on) begin
                            hp_n = 1'b1;
                        end
                    end
                    if (hp_n && restart_delay_active && (off_delay_count < off_delay_limit)) begin
                        hp_n = 1'b0;
                        req_n[svps_pkg::REQ_HOME] = 1'b1;
                    end
                end
                supply_n = |req_n;

                if (req_n[svps_pkg::REQ_HOME]) begin
                    case (home_reg)
                        HOME_START: begin
                            wait_n = power_on_ticks;
                            home_n = HOME_POWER;
                        end
                        HOME_POWER: begin
                            if (wait_reg != '0) wait_n = wait_reg - 1'b1;
                            else home_n = HOME_ARM;
                        end
                        HOME_ARM: begin
                            cmd.arm   = 1'b1;
                            cmd.where = home_position;
                            home_n    = HOME_MOVE;
                        end
                        HOME_MOVE: begin
                            if (tgt_pos == cur_pos) begin
                                cmd.zero = 1'b1;
                                home_n   = HOME_ARM_COLD;
                            end
                        end
                        HOME_ARM_COLD: begin
                            cmd.arm   = 1'b1;
                            cmd.where = cold_position;
                            home_n    = HOME_MOVE_COLD;
                        end
                        HOME_MOVE_COLD: begin
                            if (tgt_pos == cur_pos) home_n = HOME_DONE;
                        end
                        HOME_DONE: begin
                            req_n[svps_pkg::REQ_HOME] = 1'b0;
                            home_n   = HOME_START;
                            status_n = 1'b0;
                        end
                        default: home_n = HOME_START;
                    endcase
                end else if (req_n[svps_pkg::REQ_COLD] || req_n[svps_pkg::REQ_ICE]) begin
                    case (go_step)
                        GO_START: begin
                            wait_n  = power_on_ticks;
                            go_next = GO_POWER;
                        end
                        GO_POWER: begin
                            if (wait_reg != '0) wait_n = wait_reg - 1'b1;
                            else go_next = GO_CHECK;
                        end
                        GO_CHECK: go_next = (tgt_pos == go_where) ? GO_MOVE : GO_ARM;
                        GO_ARM: begin
                            cmd.arm   = 1'b1;
                            cmd.where = go_where;
                            go_next   = GO_MOVE;
                        end
                        GO_MOVE: begin
                            if (tgt_pos == cur_pos) go_next = GO_DONE;
                        end
                        GO_DONE: begin
                            go_done = 1'b1;
                            go_next = GO_START;
                        end
                        default: go_next = GO_START;
                    endcase
                    // write the shared step back to the sequence that ran
                    if (req_n[svps_pkg::REQ_COLD]) begin
                        cold_n = go_next;
                        if (go_done) begin
                            req_n[svps_pkg::REQ_COLD] = 1'b0;
                            status_n = 1'b0;
                        end
                    end else begin
                        ice_n = go_next;
                        if (go_done) begin
                            req_n[svps_pkg::REQ_ICE] = 1'b0;
                            status_n = 1'b1;
                        end
                    end
                end
            end
            svps_pkg::MODE_COLD: begin
                req_n[svps_pkg::REQ_COLD] = 1'b1;
                req_n[svps_pkg::REQ_ICE]  = 1'b0;
            end
            svps_pkg::MODE_ICE: begin
                req_n[svps_pkg::REQ_ICE]  = 1'b1;
                req_n[svps_pkg::REQ_COLD] = 1'b0;
            end
            svps_pkg::MODE_HOME: req_n[svps_pkg::REQ_HOME] = 1'b1;
            default: ;
        endcase
    end

    // Hold sequencer state, advance on each processed item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_reg       <= '0;
            home_reg      <= HOME_START;
            cold_reg      <= GO_START;
            ice_reg       <= GO_START;
            wait_reg      <= svps_pkg::POWER_ON_RST;
            status_reg    <= 1'b1;
            comp_last_reg <= 1'b0;
            hp_reg        <= 1'b1;
            supply_reg    <= 1'b0;
        end else if (advance) begin
            req_reg       <= req_n;
            home_reg      <= home_n;
            cold_reg      <= cold_n;
            ice_reg       <= ice_n;
            wait_reg      <= wait_n;
            status_reg    <= status_n;
            comp_last_reg <= comp_last_n;
            hp_reg        <= hp_n;
            supply_reg    <= supply_n;
        end
    end

    assign supply_next = supply_n;
    assign status_next = status_n;
    assign busy_next   = |req_n;

endmodule

FILE: rtl/stepper_valve_position_sequencer.sv
// Top level of the stepper valve position sequencer.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------------------------
//  s_       | in        | s_valid / s_ready  | mode, compressor_on, restart_delay_active,
//           |           |                    | off_delay_count, factory_test
//  m_       | out       | m_valid / m_ready  | coil_pattern, power_enable, valve_status,
//           |           |                    | busy_res, position_now
//  cfg_     | in        | cfg_we             | cfg_addr, cfg_wdata
//
// One item per cycle sustained while m_ready is high; each item is held in the input register
// and is worked out in one pass into the result register, which offers its result on m_valid.
// The single pass over motor and sequencer state sets this rate.
// A stalled result register holds the input register, which then holds s_ready low.
// Reset (aresetn low, synchronous) loads the register defaults and empties both stages.
module stepper_valve_position_sequencer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [svps_pkg::MODE_W-1:0]       s_mode,
    input  logic                              s_compressor_on,
    input  logic                              s_restart_delay_active,
    input  logic [svps_pkg::OFF_W-1:0]        s_off_delay_count,
    input  logic                              s_factory_test,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [svps_pkg::COIL_W-1:0]       m_coil_pattern,
    output logic                              m_power_enable,
    output logic                              m_valve_status,
    output logic                              m_busy_res,
    output logic signed [svps_pkg::POS_W-1:0] m_position_now,
    input  logic                              cfg_we,
    input  logic [svps_pkg::CFG_AW-1:0]       cfg_addr,
    input  logic [svps_pkg::CFG_DW-1:0]       cfg_wdata
);

    // Configuration registers
    svps_pkg::pos_t  home_pos_reg, cold_pos_reg, ice_pos_reg;
    svps_pkg::hold_t hold_ticks_reg;
    svps_pkg::wait_t power_on_reg;
    svps_pkg::off_t  off_limit_reg;

    // Input register
    logic            in_valid_reg;
    svps_pkg::mode_t in_mode_reg;
    logic            in_comp_reg;
    logic            in_restart_reg;
    svps_pkg::off_t  in_off_reg;
    logic            in_factory_reg;

    // Result register
    logic            out_valid_reg;
    svps_pkg::coil_t out_coil_reg;
    logic            out_power_reg;
    logic            out_status_reg;
    logic            out_busy_reg;
    svps_pkg::pos_t  out_pos_reg;

    logic                 advance;
    svps_pkg::motor_cmd_t cmd;
    svps_pkg::pos_t       cur_pos, tgt_pos, pos_next;
    svps_pkg::coil_t      coil_next;
    logic                 supply_next, status_next, busy_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            home_pos_reg   <= svps_pkg::HOME_POS_RST;
            cold_pos_reg   <= svps_pkg::COLD_POS_RST;
            ice_pos_reg    <= svps_pkg::ICE_POS_RST;
            hold_ticks_reg <= svps_pkg::HOLD_TICKS_RST;
            power_on_reg   <= svps_pkg::POWER_ON_RST;
            off_limit_reg  <= svps_pkg::OFF_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                svps_pkg::CFG_HOME_POS:   home_pos_reg   <= cfg_wdata[svps_pkg::POS_W-1:0];
                svps_pkg::CFG_COLD_POS:   cold_pos_reg   <= cfg_wdata[svps_pkg::POS_W-1:0];
                svps_pkg::CFG_ICE_POS:    ice_pos_reg    <= cfg_wdata[svps_pkg::POS_W-1:0];
                svps_pkg::CFG_HOLD_TICKS: hold_ticks_reg <= cfg_wdata[svps_pkg::HOLD_W-1:0];
                svps_pkg::CFG_POWER_ON:   power_on_reg   <= cfg_wdata[svps_pkg::WAIT_W-1:0];
                svps_pkg::CFG_OFF_LIMIT:  off_limit_reg  <= cfg_wdata[svps_pkg::OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture an item into the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_mode_reg    <= s_mode;
            in_comp_reg    <= s_compressor_on;
            in_restart_reg <= s_restart_delay_active;
            in_off_reg     <= s_off_delay_count;
            in_factory_reg <= s_factory_test;
        end
    end

    // Load the result register, drop it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_coil_reg   <= coil_next;
            out_power_reg  <= supply_next;
            out_status_reg <= status_next;
            out_busy_reg   <= busy_next;
            out_pos_reg    <= pos_next;
        end
    end

    svps_motor u_motor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .advance    (advance),
        .step_en    (in_mode_reg == svps_pkg::MODE_STEP),
        .cmd        (cmd),
        .hold_ticks (hold_ticks_reg),
        .cur_pos    (cur_pos),
        .tgt_pos    (tgt_pos),
        .coil_next  (coil_next),
        .pos_next   (pos_next)
    );

    svps_seq u_seq (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .advance              (advance),
        .mode                 (in_mode_reg),
        .compressor_on        (in_comp_reg),
        .restart_delay_active (in_restart_reg),
        .off_delay_count      (in_off_reg),
        .factory_test         (in_factory_reg),
        .home_position        (home_pos_reg),
        .cold_position        (cold_pos_reg),
        .ice_position         (ice_pos_reg),
        .power_on_ticks       (power_on_reg),
        .off_delay_limit      (off_limit_reg),
        .cur_pos              (cur_pos),
        .tgt_pos              (tgt_pos),
        .cmd                  (cmd),
        .supply_next          (supply_next),
        .status_next          (status_next),
        .busy_next            (busy_next)
    );

    assign m_valid        = out_valid_reg;
    assign m_coil_pattern = out_coil_reg;
    assign m_power_enable = out_power_reg;
    assign m_valve_status = out_status_reg;
    assign m_busy_res     = out_busy_reg;
    assign m_position_now = out_pos_reg;

endmodule
